// ----- rtl/core/mpph_pkg.sv -----
// ----------------------------------------------------------------------------
// mpph_pkg
// Shared types and constants of the three-axis PID position hold unit.
// ----------------------------------------------------------------------------
package mpph_pkg;

    localparam int NUM_AXES  = 3;
    localparam int PID_AXES  = (NUM_AXES < 3) ? NUM_AXES : 3;
    localparam int N_OUT     = 4;
    localparam int DATA_W    = 32;
    localparam int GAIN_W    = 16;
    localparam int ADDR_W    = 5;
    localparam int AX_W      = 2;
    localparam int ISUM_W    = 64;

    localparam int MAG_W     = 96;
    localparam int MB_W      = 34;
    localparam int CNT_W     = 7;
    localparam int MUL_STEPS = MB_W;
    localparam int DIV_STEPS = MAG_W;

    localparam logic [MAG_W-1:0] ISUM_CLAMP = MAG_W'(1) << 47;
    localparam logic [MAG_W-1:0] QUOT_CAP   = MAG_W'(1) << 40;
    localparam logic [MB_W-1:0]  MS_PER_S   = MB_W'(1000);

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_arith_req;

    typedef enum logic [2:0] {
        REG_GAIN_PROP     = 3'd0,
        REG_GAIN_INTEGRAL = 3'd1,
        REG_GAIN_DERIV    = 3'd2,
        REG_PID_LOW       = 3'd3,
        REG_PID_HIGH      = 3'd4,
        REG_DRIVE_LOW     = 3'd5,
        REG_DRIVE_HIGH    = 3'd6
    } t_reg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_AXIS,
        ST_PDT,
        ST_ACC,
        ST_DER,
        ST_ISTART,
        ST_INT,
        ST_KPG,
        ST_KP,
        ST_KIG,
        ST_KI,
        ST_KDG,
        ST_KD,
        ST_SAT,
        ST_MAP,
        ST_MMUL,
        ST_MDG,
        ST_MDIV,
        ST_NEXT,
        ST_OUT
    } t_state;

    function automatic logic [DATA_W-1:0] neg_sat32(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] r;
        if (v == {1'b1, {(DATA_W-1){1'b0}}}) begin
            r = {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            r = ~v + DATA_W'(1);
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/mpph_arith.sv -----
// ----------------------------------------------------------------------------
// mpph_arith
// Shared bit-serial unit: shift-add multiply and restoring divide on
// unsigned magnitudes, one bit per cycle.
// ----------------------------------------------------------------------------
module mpph_arith (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mpph_pkg::t_arith_req            i_req,
    input  logic [mpph_pkg::MAG_W-1:0]      i_a,
    input  logic [mpph_pkg::MB_W-1:0]       i_b,
    output logic                            o_done,
    output logic [mpph_pkg::MAG_W-1:0]      o_result
);

    logic                         r_busy;
    logic                         r_done;
    mpph_pkg::t_op                r_op;
    logic [mpph_pkg::CNT_W-1:0]   r_cnt;
    logic [mpph_pkg::MAG_W-1:0]   r_acc;
    logic [mpph_pkg::MAG_W-1:0]   r_x;
    logic [mpph_pkg::MB_W-1:0]    r_b;
    logic [mpph_pkg::MB_W-1:0]    r_rem;

    logic [mpph_pkg::MB_W:0]      trial;
    logic                         fits;

    assign trial = {r_rem, r_x[mpph_pkg::MAG_W-1]};
    assign fits  = (trial >= {1'b0, r_b});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= (i_req.op == mpph_pkg::OP_MUL) ?
                          mpph_pkg::CNT_W'(mpph_pkg::MUL_STEPS) :
                          mpph_pkg::CNT_W'(mpph_pkg::DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - mpph_pkg::CNT_W'(1);
                if (r_cnt == mpph_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op  <= i_req.op;
            r_acc <= '0;
            r_x   <= i_a;
            r_b   <= i_b;
            r_rem <= '0;
        end else if (r_busy) begin
            case (r_op)
                mpph_pkg::OP_MUL: begin
                    if (r_b[0]) begin
                        r_acc <= r_acc + r_x;
                    end
                    r_x <= {r_x[mpph_pkg::MAG_W-2:0], 1'b0};
                    r_b <= {1'b0, r_b[mpph_pkg::MB_W-1:1]};
                end
                mpph_pkg::OP_DIV: begin
                    if (fits) begin
                        r_rem <= mpph_pkg::MB_W'(trial - {1'b0, r_b});
                    end else begin
                        r_rem <= trial[mpph_pkg::MB_W-1:0];
                    end
                    r_x <= {r_x[mpph_pkg::MAG_W-2:0], fits};
                end
                default: begin
                    r_x <= r_x;
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = (r_op == mpph_pkg::OP_MUL) ? r_acc : r_x;

endmodule

// ----- rtl/core/multi_axis_pid_position_hold_unit.sv -----
// ----------------------------------------------------------------------------
// multi_axis_pid_position_hold_unit
// Three-axis PID position hold: integral, derivative, gains, range mapping.
// ----------------------------------------------------------------------------
// Every product and quotient runs through one shared bit-serial unit: five
// multiplies and three divides per PID axis plus one map for yaw. Zero
// elapsed time skips the derivative divide, and an empty PID range skips each
// map. One item is worked on at a time; the finished result sits in an
// output register so the next item is taken while it waits.
// ----------------------------------------------------------------------------
module multi_axis_pid_position_hold_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // err_x, err_y, err_z, stamp_ms
    input  logic [4*mpph_pkg::DATA_W-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // linear_x, linear_y, linear_z, angular_z
    output logic [4*mpph_pkg::DATA_W-1:0]     m_axis_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mpph_pkg::ADDR_W-1:0]       paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int W  = mpph_pkg::DATA_W;
    localparam int GW = mpph_pkg::GAIN_W;
    localparam int MW = mpph_pkg::MAG_W;
    localparam int BW = mpph_pkg::MB_W;
    localparam int IW = mpph_pkg::ISUM_W;

    // configuration
    logic signed [GW-1:0] r_gp, r_gi, r_gd;
    logic signed [W-1:0]  r_pl, r_ph, r_dl, r_dh;

    // control
    mpph_pkg::t_state r_state, n_state;
    logic [mpph_pkg::AX_W-1:0] r_k;
    logic r_ovalid;

    // state
    logic signed [W-1:0]  r_prev_err [0:mpph_pkg::PID_AXES-1];
    logic signed [IW-1:0] r_isum     [0:mpph_pkg::PID_AXES-1];
    logic [W-1:0]         r_prev_stamp;

    // per item work
    logic signed [W-1:0]  r_err [0:mpph_pkg::PID_AXES-1];
    logic [W-1:0]         r_dt;
    logic signed [44:0]   r_d;
    logic signed [48:0]   r_is;
    logic signed [63:0]   r_sum;
    logic signed [W-1:0]  r_v;
    logic                 r_msgn;
    logic signed [W-1:0]  r_m [0:mpph_pkg::N_OUT-1];
    logic [4*W-1:0]       r_out;

    mpph_pkg::t_arith_req req;
    logic [MW-1:0] arith_a;
    logic [BW-1:0] arith_b;
    logic          arith_done;
    logic [MW-1:0] arith_res;

    mpph_arith u_arith (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (req),
        .i_a      (arith_a),
        .i_b      (arith_b),
        .o_done   (arith_done),
        .o_result (arith_res)
    );

    // operands of the current axis
    logic signed [W-1:0]  e, pe;
    logic signed [IW-1:0] isum;
    logic                 is_pid;
    logic [W-1:0]         e_mag;
    logic signed [W:0]    diff;
    logic [W:0]           diff_mag;
    logic [42:0]          diff_k;
    logic [IW-1:0]        isum_mag;
    logic [47:0]          is_mag;
    logic [43:0]          d_mag;
    logic [GW-1:0]        gp_mag, gi_mag, gd_mag;
    logic signed [W:0]    map_a, map_b, map_den;
    logic [W:0]           map_a_mag, map_b_mag, den_mag;
    logic                 in_acc, cfg_wr;

    assign is_pid   = (r_k < mpph_pkg::AX_W'(mpph_pkg::PID_AXES));
    assign e        = is_pid ? r_err[r_k] : '0;
    assign pe       = is_pid ? r_prev_err[r_k] : '0;
    assign isum     = is_pid ? r_isum[r_k] : '0;
    assign e_mag    = e[W-1] ? (~e + W'(1)) : e;
    assign diff     = {e[W-1], e} - {pe[W-1], pe};
    assign diff_mag = diff[W] ? (~diff + (W+1)'(1)) : diff;
    assign diff_k   = {diff_mag, 10'd0} - 43'({diff_mag, 4'd0}) - 43'({diff_mag, 3'd0});
    assign isum_mag = isum[IW-1] ? (~isum + IW'(1)) : isum;
    assign is_mag   = 48'(r_is[48] ? (~r_is + 49'sd1) : r_is);
    assign d_mag    = 44'(r_d[44] ? (~r_d + 45'sd1) : r_d);
    assign gp_mag   = r_gp[GW-1] ? (~r_gp + GW'(1)) : r_gp;
    assign gi_mag   = r_gi[GW-1] ? (~r_gi + GW'(1)) : r_gi;
    assign gd_mag   = r_gd[GW-1] ? (~r_gd + GW'(1)) : r_gd;
    assign map_a    = {r_v[W-1], r_v} - {r_pl[W-1], r_pl};
    assign map_b    = {r_dh[W-1], r_dh} - {r_dl[W-1], r_dl};
    assign map_den  = {r_ph[W-1], r_ph} - {r_pl[W-1], r_pl};
    assign map_a_mag = map_a[W] ? (~map_a + (W+1)'(1)) : map_a;
    assign map_b_mag = map_b[W] ? (~map_b + (W+1)'(1)) : map_b;
    assign den_mag   = map_den[W] ? (~map_den + (W+1)'(1)) : map_den;

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign cfg_wr = psel && penable && pwrite && pready;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mpph_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        req.start = 1'b0;
        req.op    = mpph_pkg::OP_MUL;
        arith_a   = '0;
        arith_b   = '0;
        case (r_state)
            mpph_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = mpph_pkg::ST_AXIS;
                end
            end
            mpph_pkg::ST_AXIS: begin
                if (is_pid) begin
                    req.start = 1'b1;
                    arith_a   = MW'(e_mag);
                    arith_b   = BW'(r_dt);
                    n_state   = mpph_pkg::ST_PDT;
                end else begin
                    n_state = mpph_pkg::ST_MAP;
                end
            end
            mpph_pkg::ST_PDT: begin
                if (arith_done) begin
                    n_state = mpph_pkg::ST_ACC;
                end
            end
            mpph_pkg::ST_ACC: begin
                if (r_dt != '0) begin
                    req.start = 1'b1;
                    req.op    = mpph_pkg::OP_DIV;
                    arith_a   = MW'(diff_k);
                    arith_b   = BW'(r_dt);
                    n_state   = mpph_pkg::ST_DER;
                end else begin
                    n_state = mpph_pkg::ST_ISTART;
                end
            end
            mpph_pkg::ST_DER: begin
                if (arith_done) begin
                    n_state = mpph_pkg::ST_ISTART;
                end
            end
            mpph_pkg::ST_ISTART: begin
                req.start = 1'b1;
                req.op    = mpph_pkg::OP_DIV;
                arith_a   = MW'(isum_mag);
                arith_b   = mpph_pkg::MS_PER_S;
                n_state   = mpph_pkg::ST_INT;
            end
            mpph_pkg::ST_INT: begin
                if (arith_done) begin
                    n_state = mpph_pkg::ST_KPG;
                end
            end
            mpph_pkg::ST_KPG: begin
                req.start = 1'b1;
                arith_a   = MW'(e_mag);
                arith_b   = BW'(gp_mag);
                n_state   = mpph_pkg::ST_KP;
            end
            mpph_pkg::ST_KP: begin
                if (arith_done) begin
                    n_state = mpph_pkg::ST_KIG;
                end
            end
            mpph_pkg::ST_KIG: begin
                req.start = 1'b1;
                arith_a   = MW'(is_mag);
                arith_b   = BW'(gi_mag);
                n_state   = mpph_pkg::ST_KI;
            end
            mpph_pkg::ST_KI: begin
                if (arith_done) begin
                    n_state = mpph_pkg::ST_KDG;
                end
            end
            mpph_pkg::ST_KDG: begin
                req.start = 1'b1;
                arith_a   = MW'(d_mag);
                arith_b   = BW'(gd_mag);
                n_state   = mpph_pkg::ST_KD;
            end
            mpph_pkg::ST_KD: begin
                if (arith_done) begin
                    n_state = mpph_pkg::ST_SAT;
                end
            end
            mpph_pkg::ST_SAT: begin
                n_state = mpph_pkg::ST_MAP;
            end
            mpph_pkg::ST_MAP: begin
                if (map_den == '0) begin
                    n_state = mpph_pkg::ST_NEXT;
                end else begin
                    req.start = 1'b1;
                    arith_a   = MW'(map_a_mag);
                    arith_b   = BW'(map_b_mag);
                    n_state   = mpph_pkg::ST_MMUL;
                end
            end
            mpph_pkg::ST_MMUL: begin
                if (arith_done) begin
                    n_state = mpph_pkg::ST_MDG;
                end
            end
            mpph_pkg::ST_MDG: begin
                req.start = 1'b1;
                req.op    = mpph_pkg::OP_DIV;
                arith_a   = arith_res;
                arith_b   = BW'(den_mag);
                n_state   = mpph_pkg::ST_MDIV;
            end
            mpph_pkg::ST_MDIV: begin
                if (arith_done) begin
                    n_state = mpph_pkg::ST_NEXT;
                end
            end
            mpph_pkg::ST_NEXT: begin
                if (r_k == mpph_pkg::AX_W'(mpph_pkg::N_OUT - 1)) begin
                    n_state = mpph_pkg::ST_OUT;
                end else begin
                    n_state = mpph_pkg::ST_AXIS;
                end
            end
            mpph_pkg::ST_OUT: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_state = mpph_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mpph_pkg::ST_IDLE;
            end
        endcase
    end

    // results of the shared unit
    logic [IW:0]   prod_s, isum_sum;
    logic [63:0]   term_mag;
    logic [63:0]   term_s;
    logic          term_neg;
    logic [47:0]   is_q;
    logic [40:0]   map_q;
    logic [42:0]   map_sv, map_t;
    logic [W-1:0]  map_sat, sum_sat;

    assign prod_s   = e[W-1] ? (~{1'b0, arith_res[IW-1:0]} + (IW+1)'(1))
                             : {1'b0, arith_res[IW-1:0]};
    assign isum_sum = {isum[IW-1], isum} + prod_s;
    assign term_mag = arith_res[71:8];
    always_comb begin
        case (r_state)
            mpph_pkg::ST_KP: term_neg = e[W-1] ^ r_gp[GW-1];
            mpph_pkg::ST_KI: term_neg = r_is[48] ^ r_gi[GW-1];
            mpph_pkg::ST_KD: term_neg = r_d[44] ^ r_gd[GW-1];
            default:         term_neg = 1'b0;
        endcase
    end
    assign term_s = term_neg ? (~term_mag + 64'd1) : term_mag;
    assign is_q   = (arith_res > mpph_pkg::ISUM_CLAMP) ? 48'(mpph_pkg::ISUM_CLAMP)
                                                       : arith_res[47:0];
    assign map_q  = (arith_res > mpph_pkg::QUOT_CAP) ? 41'(mpph_pkg::QUOT_CAP)
                                                     : arith_res[40:0];
    assign map_sv = r_msgn ? (~{2'b00, map_q} + 43'd1) : {2'b00, map_q};
    assign map_t  = map_sv + {{11{r_dl[W-1]}}, r_dl};
    assign map_sat = (map_t[42:31] == '0 || map_t[42:31] == '1) ? map_t[W-1:0] :
                     (map_t[42] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});
    assign sum_sat = (r_sum[63:31] == '0 || r_sum[63:31] == '1) ? r_sum[W-1:0] :
                     (r_sum[63] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});

    // state that reset clears
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gp         <= 16'sd256;
            r_gi         <= '0;
            r_gd         <= '0;
            r_pl         <= -32'sd327680;
            r_ph         <= 32'sd327680;
            r_dl         <= -32'sd65536;
            r_dh         <= 32'sd65536;
            r_prev_stamp <= '0;
            r_k          <= '0;
            r_ovalid     <= 1'b0;
            for (int i = 0; i < mpph_pkg::PID_AXES; i++) begin
                r_prev_err[i] <= '0;
                r_isum[i]     <= '0;
            end
        end else begin
            if (cfg_wr) begin
                case (paddr[mpph_pkg::ADDR_W-1:2])
                    mpph_pkg::REG_GAIN_PROP:     r_gp <= pwdata[GW-1:0];
                    mpph_pkg::REG_GAIN_INTEGRAL: r_gi <= pwdata[GW-1:0];
                    mpph_pkg::REG_GAIN_DERIV:    r_gd <= pwdata[GW-1:0];
                    mpph_pkg::REG_PID_LOW:       r_pl <= pwdata;
                    mpph_pkg::REG_PID_HIGH:      r_ph <= pwdata;
                    mpph_pkg::REG_DRIVE_LOW:     r_dl <= pwdata;
                    mpph_pkg::REG_DRIVE_HIGH:    r_dh <= pwdata;
                    default: begin
                        r_gp <= r_gp;
                    end
                endcase
            end
            if (in_acc) begin
                r_prev_stamp <= s_axis_tdata[4*W-1:3*W];
                r_k          <= '0;
            end
            if (r_state == mpph_pkg::ST_PDT && arith_done) begin
                if (isum_sum[IW] != isum_sum[IW-1]) begin
                    r_isum[r_k] <= isum_sum[IW] ? {1'b1, {(IW-1){1'b0}}}
                                                : {1'b0, {(IW-1){1'b1}}};
                end else begin
                    r_isum[r_k] <= isum_sum[IW-1:0];
                end
            end
            if (r_state == mpph_pkg::ST_SAT) begin
                r_prev_err[r_k] <= e;
            end
            if (r_state == mpph_pkg::ST_NEXT) begin
                r_k <= r_k + mpph_pkg::AX_W'(1);
            end
            if (r_state == mpph_pkg::ST_OUT && (!r_ovalid || m_axis_tready)) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // per item datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int i = 0; i < mpph_pkg::PID_AXES; i++) begin
                r_err[i] <= s_axis_tdata[i*W +: W];
            end
            r_dt <= s_axis_tdata[4*W-1:3*W] - r_prev_stamp;
        end
        case (r_state)
            mpph_pkg::ST_AXIS: begin
                r_v <= '0;
            end
            mpph_pkg::ST_ACC: begin
                r_d <= '0;
            end
            mpph_pkg::ST_DER: begin
                if (arith_done) begin
                    r_d <= diff[W] ? (~{1'b0, arith_res[43:0]} + 45'd1)
                                   : {1'b0, arith_res[43:0]};
                end
            end
            mpph_pkg::ST_INT: begin
                if (arith_done) begin
                    r_is <= isum[IW-1] ? (~{1'b0, is_q} + 49'd1) : {1'b0, is_q};
                end
            end
            mpph_pkg::ST_KP: begin
                if (arith_done) begin
                    r_sum <= term_s;
                end
            end
            mpph_pkg::ST_KI, mpph_pkg::ST_KD: begin
                if (arith_done) begin
                    r_sum <= r_sum + term_s;
                end
            end
            mpph_pkg::ST_SAT: begin
                r_v <= sum_sat;
            end
            mpph_pkg::ST_MAP: begin
                r_msgn <= map_a[W] ^ map_b[W] ^ map_den[W];
                if (map_den == '0) begin
                    r_m[r_k] <= r_dl;
                end
            end
            mpph_pkg::ST_MDIV: begin
                if (arith_done) begin
                    r_m[r_k] <= map_sat;
                end
            end
            mpph_pkg::ST_OUT: begin
                if (!r_ovalid || m_axis_tready) begin
                    r_out <= {r_m[3],
                              mpph_pkg::neg_sat32(r_m[2]),
                              mpph_pkg::neg_sat32(r_m[0]),
                              mpph_pkg::neg_sat32(r_m[1])};
                end
            end
            default: begin
                r_msgn <= r_msgn;
            end
        endcase
    end

    always_comb begin
        case (paddr[mpph_pkg::ADDR_W-1:2])
            mpph_pkg::REG_GAIN_PROP:     prdata = 32'(r_gp);
            mpph_pkg::REG_GAIN_INTEGRAL: prdata = 32'(r_gi);
            mpph_pkg::REG_GAIN_DERIV:    prdata = 32'(r_gd);
            mpph_pkg::REG_PID_LOW:       prdata = r_pl;
            mpph_pkg::REG_PID_HIGH:      prdata = r_ph;
            mpph_pkg::REG_DRIVE_LOW:     prdata = r_dl;
            mpph_pkg::REG_DRIVE_HIGH:    prdata = r_dh;
            default:                     prdata = '0;
        endcase
    end

    assign pready        = 1'b1;
    assign s_axis_tready = (r_state == mpph_pkg::ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out;

endmodule

// ----- rtl/core/mpph_checker.sv -----
// ----------------------------------------------------------------------------
// mpph_checker
// Port-level checks of the PID position hold unit, bound to the top level.
// ----------------------------------------------------------------------------
module mpph_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [4*mpph_pkg::DATA_W-1:0] m_axis_tdata,
    input logic                          pready
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item taken while busy");

    // taking an item does not raise a result at once
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result without work");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready && pready)
        else $error("bad state after reset");

endmodule

bind multi_axis_pid_position_hold_unit mpph_checker u_mpph_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pready        (pready)
);
